@@ hw/rtl/scaled_clipped_blit_unit_assert.svh @@
// Assertion macros shared by the blit unit checker.
`ifndef SCALED_CLIPPED_BLIT_UNIT_ASSERT_SVH
`define SCALED_CLIPPED_BLIT_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define SCB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: label failed");

// next-cycle implication, off during reset
`define SCB_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: label failed");

// next-cycle implication that also checks the reset itself
`define SCB_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

@@ hw/rtl/scb_pkg.sv @@
// Types and constants for the scaled clipped blit unit.
package scb_pkg;

   localparam int CoordW  = 10;
   localparam int SizeW   = 11;
   localparam int ScaleW  = 4;
   localparam int PixelW  = 32;
   localparam int AddrW   = 20;
   localparam int PosW    = 16;   // signed scaled destination position
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 11;
   localparam int QDepth  = 4;
   localparam int QPtrW   = 2;
   localparam int QCntW   = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DEST_ORIGIN_X = 3'd0,
      CSR_DEST_ORIGIN_Y = 3'd1,
      CSR_SCALE_FACTOR  = 3'd2,
      CSR_RECT_LEFT     = 3'd3,
      CSR_RECT_TOP      = 3'd4,
      CSR_SOURCE_WIDTH  = 3'd5,
      CSR_SOURCE_HEIGHT = 3'd6,
      CSR_UNUSED        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               valid;
      logic [CsrIdxW-1:0] index;
      logic [CsrDatW-1:0] wdata;
   } csr_write_type;

   // one classified source pixel waiting for replication
   typedef struct packed {
      logic [PixelW-1:0]      pixel;
      logic signed [PosW-1:0] base_x;
      logic signed [PosW-1:0] base_y;
      logic [ScaleW-1:0]      scale;
      logic                   eor;
   } scb_entry_type;

endpackage

@@ hw/rtl/scb_front.sv @@
// Front end: configuration registers, pixel range check and base position.
module scb_front import scb_pkg::*; #(
   parameter int MAX_SCALE = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  csr_write_type       csr_wr,
   input  logic [CoordW-1:0]   src_col,
   input  logic [CoordW-1:0]   src_row,
   input  logic [PixelW-1:0]   src_pixel,
   input  logic                end_of_rect,
   output scb_entry_type       entry
);

   localparam logic [ScaleW-1:0] MaxScaleW = ScaleW'(MAX_SCALE);

   logic [CoordW-1:0] dest_x_ff, dest_x_in, dest_y_ff, dest_y_in;
   logic [CoordW-1:0] rect_left_ff, rect_left_in, rect_top_ff, rect_top_in;
   logic [ScaleW-1:0] scale_ff, scale_in;
   logic [SizeW-1:0]  src_w_ff, src_w_in, src_h_ff, src_h_in;

   logic [ScaleW-1:0]      eff_scale;
   logic signed [PosW-1:0] off_x, off_y, scale_s;
   logic                   in_range;

   always_comb begin
      dest_x_in    = dest_x_ff;
      dest_y_in    = dest_y_ff;
      scale_in     = scale_ff;
      rect_left_in = rect_left_ff;
      rect_top_in  = rect_top_ff;
      src_w_in     = src_w_ff;
      src_h_in     = src_h_ff;
      if (csr_wr.valid) begin
         case (csr_index_type'(csr_wr.index))
            CSR_DEST_ORIGIN_X: dest_x_in    = csr_wr.wdata[CoordW-1:0];
            CSR_DEST_ORIGIN_Y: dest_y_in    = csr_wr.wdata[CoordW-1:0];
            CSR_SCALE_FACTOR:  scale_in     = csr_wr.wdata[ScaleW-1:0];
            CSR_RECT_LEFT:     rect_left_in = csr_wr.wdata[CoordW-1:0];
            CSR_RECT_TOP:      rect_top_in  = csr_wr.wdata[CoordW-1:0];
            CSR_SOURCE_WIDTH:  src_w_in     = csr_wr.wdata;
            CSR_SOURCE_HEIGHT: src_h_in     = csr_wr.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff    <= '0;
         dest_y_ff    <= '0;
         scale_ff     <= ScaleW'(1);
         rect_left_ff <= '0;
         rect_top_ff  <= '0;
         src_w_ff     <= '0;
         src_h_ff     <= '0;
      end else begin
         dest_x_ff    <= dest_x_in;
         dest_y_ff    <= dest_y_in;
         scale_ff     <= scale_in;
         rect_left_ff <= rect_left_in;
         rect_top_ff  <= rect_top_in;
         src_w_ff     <= src_w_in;
         src_h_ff     <= src_h_in;
      end
   end

   always_comb begin
      if (scale_ff == '0)
         eff_scale = ScaleW'(1);
      else if (scale_ff > MaxScaleW)
         eff_scale = MaxScaleW;
      else
         eff_scale = scale_ff;

      scale_s = $signed(PosW'(eff_scale));
      // origin + (coord - rect corner), may go negative
      off_x = $signed(PosW'(dest_x_ff)) + $signed(PosW'(src_col))
            - $signed(PosW'(rect_left_ff));
      off_y = $signed(PosW'(dest_y_ff)) + $signed(PosW'(src_row))
            - $signed(PosW'(rect_top_ff));

      in_range = (SizeW'(src_col) < src_w_ff) && (SizeW'(src_row) < src_h_ff);

      entry.pixel  = in_range ? src_pixel : '0;
      entry.base_x = off_x * scale_s;
      entry.base_y = off_y * scale_s;
      entry.scale  = eff_scale;
      entry.eor    = end_of_rect;
   end

endmodule

@@ hw/rtl/scb_fifo.sv @@
// Short queue between the front end and the write generator.
module scb_fifo import scb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  scb_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output scb_entry_type head
);

   scb_entry_type           mem_ff [QDepth];
   logic [QPtrW-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == QCntW'(QDepth));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCntW'(do_push) - QCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ hw/rtl/scb_back.sv @@
// Back end: walks the replica offsets of one pixel and drives the write register.
module scb_back import scb_pkg::*; #(
   parameter int FB_WIDTH  = 1024,
   parameter int FB_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  scb_entry_type     q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [AddrW-1:0]  rsp_write_address,
   output logic [PixelW-1:0] rsp_write_pixel,
   output logic              rsp_write_enable,
   output logic              rsp_last_replica,
   output logic              rsp_blit_done
);

   localparam int ProdW = 25;
   localparam logic signed [PosW-1:0] FbW = PosW'(FB_WIDTH);
   localparam logic signed [PosW-1:0] FbH = PosW'(FB_HEIGHT);
   localparam logic [ProdW-1:0]       FbWidthP = ProdW'(FB_WIDTH);

   scb_entry_type     cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic [ScaleW-1:0] cx_ff, cx_in, cy_ff, cy_in;

   logic              out_valid_ff, out_valid_in;
   logic [AddrW-1:0]  out_addr_ff, out_addr_in;
   logic [PixelW-1:0] out_pix_ff, out_pix_in;
   logic              out_en_ff, out_en_in, out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;

   logic                   out_free, advance, last_col, last_row, last, load;
   logic signed [PosW-1:0] x, y;
   logic                   en;
   logic [ProdW-1:0]       lin_addr;

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      advance  = busy_ff && out_free;
      last_col = (cx_ff == cur_ff.scale - ScaleW'(1));
      last_row = (cy_ff == cur_ff.scale - ScaleW'(1));
      last     = last_col && last_row;
      // next pixel is picked up in the same cycle the previous one finishes
      load     = q_not_empty && (!busy_ff || (advance && last));
      q_pop    = load;

      x  = cur_ff.base_x + $signed(PosW'(cx_ff));
      y  = cur_ff.base_y + $signed(PosW'(cy_ff));
      en = (x >= 0) && (x < FbW) && (y >= 0) && (y < FbH);
      lin_addr = ProdW'(y[11:0]) * FbWidthP + ProdW'(x[11:0]);

      cur_in  = load ? q_head : cur_ff;
      busy_in = busy_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      if (load) begin
         busy_in = 1'b1;
         cx_in   = '0;
         cy_in   = '0;
      end else if (advance) begin
         if (last) begin
            busy_in = 1'b0;
         end else if (last_row) begin
            cy_in = '0;
            cx_in = cx_ff + ScaleW'(1);
         end else begin
            cy_in = cy_ff + ScaleW'(1);
         end
      end

      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_pix_in   = out_pix_ff;
      out_en_in    = out_en_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (out_free) begin
         out_valid_in = advance;
         out_addr_in  = en ? lin_addr[AddrW-1:0] : '0;
         out_pix_in   = cur_ff.pixel;
         out_en_in    = en;
         out_last_in  = last;
         out_done_in  = last && cur_ff.eor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_addr_ff <= out_addr_in;
      out_pix_ff  <= out_pix_in;
      out_en_ff   <= out_en_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_write_pixel   = out_pix_ff;
   assign rsp_write_enable  = out_en_ff;
   assign rsp_last_replica  = out_last_ff;
   assign rsp_blit_done     = out_done_ff;

endmodule

@@ hw/rtl/scaled_clipped_blit_unit.sv @@
// Scaled clipped blit unit: one source pixel in, scale*scale framebuffer writes out.
//
// Input channel (req_*): one source pixel per transaction with its column, row
// and an end-of-rectangle mark; accepted when req_valid is high and req_stall low.
// Result channel (rsp_*): one framebuffer write per transaction, accepted when
// rsp_valid is high and rsp_stall low. Replicas go column offset outer, row
// offset inner; writes outside the framebuffer have write_enable clear and
// address zero. last_replica marks the final write of a pixel, blit_done the
// final write of the pixel marked end_of_rect.
// Configuration (csr_*): register index and data, always ready; write only
// while the unit is idle.
// A pixel reaches the queue, then the pixel register; its writes leave through
// the output register. Each pixel gives scale*scale writes (1 to 64); the write
// generator emits one per cycle while rsp is not stalled and starts the next
// queued pixel with no gap. A 4-entry queue lets the front take pixels meanwhile.
// Reset clears the queue and the output register and loads the register
// defaults (scale 1, all others zero). A stall on rsp holds the write steady;
// once the queue fills, req_stall rises.
module scaled_clipped_blit_unit import scb_pkg::*; #(
   parameter int FB_WIDTH  = 1024,
   parameter int FB_HEIGHT = 1024,
   parameter int MAX_SCALE = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDatW-1:0] csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CoordW-1:0]  req_src_col,
   input  logic [CoordW-1:0]  req_src_row,
   input  logic [PixelW-1:0]  req_src_pixel,
   input  logic               req_end_of_rect,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [AddrW-1:0]   rsp_write_address,
   output logic [PixelW-1:0]  rsp_write_pixel,
   output logic               rsp_write_enable,
   output logic               rsp_last_replica,
   output logic               rsp_blit_done
);

   csr_write_type csr_wr;
   scb_entry_type front_entry, q_head;
   logic          q_full, q_not_empty, q_pop;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.wdata = csr_wdata;
   assign req_stall    = q_full;

   scb_front #(
      .MAX_SCALE(MAX_SCALE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr      (csr_wr),
      .src_col     (req_src_col),
      .src_row     (req_src_row),
      .src_pixel   (req_src_pixel),
      .end_of_rect (req_end_of_rect),
      .entry       (front_entry)
   );

   scb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   scb_back #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_pixel   (rsp_write_pixel),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_last_replica  (rsp_last_replica),
      .rsp_blit_done     (rsp_blit_done)
   );

endmodule

@@ hw/rtl/scb_checker.sv @@
// Port-level checks for the scaled clipped blit unit, bound to the top level.
`include "scaled_clipped_blit_unit_assert.svh"

module scb_checker import scb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [AddrW-1:0]  rsp_write_address,
   input logic [PixelW-1:0] rsp_write_pixel,
   input logic              rsp_write_enable,
   input logic              rsp_last_replica,
   input logic              rsp_blit_done
);

   // end of the rectangle can only fall on the last replica of a pixel
   `SCB_ASSERT_IMP(a_done_on_last, rsp_valid && rsp_blit_done, rsp_last_replica)
   // clipped writes carry a zero address
   `SCB_ASSERT_IMP(a_clip_addr_zero, rsp_valid && !rsp_write_enable,
                   rsp_write_address == '0)
   // a stalled write stays put
   `SCB_ASSERT_NXT(a_stall_hold, rsp_valid && rsp_stall,
                   rsp_valid && $stable(rsp_write_address) && $stable(rsp_write_pixel))
   // nothing is offered right after reset
   `SCB_ASSERT_RST(a_reset_idle, reset, !rsp_valid)

endmodule

bind scaled_clipped_blit_unit scb_checker u_scb_checker (.*);

@@ tb/tb_scaled_clipped_blit_unit.sv @@
// Self-checking testbench for the scaled clipped blit unit.
module tb_scaled_clipped_blit_unit;
   import scb_pkg::*;

   localparam int FbWidth  = 1024;
   localparam int FbHeight = 1024;
   localparam int MaxScale = 8;

   // one expected framebuffer write
   typedef struct packed {
      logic [AddrW-1:0]  addr;
      logic [PixelW-1:0] pixel;
      logic              en;
      logic              last;
      logic              done;
   } fb_write_type;

   // one row of the directed table: a register write or a source pixel
   typedef struct {
      bit                 is_csr;
      csr_index_type      idx;
      logic [CsrDatW-1:0] wdata;
      logic [CoordW-1:0]  col;
      logic [CoordW-1:0]  row;
      logic [PixelW-1:0]  pix;
      logic               eor;
      bit                 typed;
      fb_write_type       want;
   } blit_step_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDatW-1:0] csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CoordW-1:0]  req_src_col = '0;
   logic [CoordW-1:0]  req_src_row = '0;
   logic [PixelW-1:0]  req_src_pixel = '0;
   logic               req_end_of_rect = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [AddrW-1:0]   rsp_write_address;
   logic [PixelW-1:0]  rsp_write_pixel;
   logic               rsp_write_enable;
   logic               rsp_last_replica;
   logic               rsp_blit_done;

   // shadow copy of the register file
   logic [CoordW-1:0]  dest_x_r = '0;
   logic [CoordW-1:0]  dest_y_r = '0;
   logic [ScaleW-1:0]  scale_r = 4'd1;
   logic [CoordW-1:0]  rect_l_r = '0;
   logic [CoordW-1:0]  rect_t_r = '0;
   logic [SizeW-1:0]   src_w_r = '0;
   logic [SizeW-1:0]   src_h_r = '0;

   fb_write_type  pending_writes[$];
   blit_step_type directed_steps[$];
   bit            calm = 1'b0;
   int            errors = 0;
   int            pixels_sent = 0;
   int            writes_seen = 0;
   int            reg_writes = 0;

   scaled_clipped_blit_unit #(
      .FB_WIDTH  (FbWidth),
      .FB_HEIGHT (FbHeight),
      .MAX_SCALE (MaxScale)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_src_col       (req_src_col),
      .req_src_row       (req_src_row),
      .req_src_pixel     (req_src_pixel),
      .req_end_of_rect   (req_end_of_rect),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_pixel   (rsp_write_pixel),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_last_replica  (rsp_last_replica),
      .rsp_blit_done     (rsp_blit_done)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #800000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch on %s: got %0h want %0h (write %0d)", what, got, want, writes_seen);
   endtask

   // expands one source pixel into its scale*scale replica writes
   function automatic void replicate_pixel(input logic [CoordW-1:0] col,
                                           input logic [CoordW-1:0] row,
                                           input logic [PixelW-1:0] pix,
                                           input logic eor);
      int           s;
      int           bx;
      int           by;
      int           x;
      int           y;
      logic [31:0]  lin;
      fb_write_type w;
      s = (scale_r == 0) ? 1 : (scale_r > MaxScale) ? MaxScale : int'(scale_r);
      bx = int'(dest_x_r) * s + (int'(col) - int'(rect_l_r)) * s;
      by = int'(dest_y_r) * s + (int'(row) - int'(rect_t_r)) * s;
      w.pixel = (col >= src_w_r || row >= src_h_r) ? '0 : pix;
      for (int cx = 0; cx < s; cx++) begin
         for (int cy = 0; cy < s; cy++) begin
            x = bx + cx;
            y = by + cy;
            w.en = (x >= 0 && x < FbWidth && y >= 0 && y < FbHeight);
            lin = y * FbWidth + x;
            w.addr = w.en ? lin[AddrW-1:0] : '0;
            w.last = (cx == s - 1) && (cy == s - 1);
            w.done = w.last && eor;
            pending_writes.push_back(w);
         end
      end
   endfunction

   function automatic blit_step_type reg_row(input csr_index_type idx,
                                             input logic [CsrDatW-1:0] data);
      blit_step_type st;
      st = '{idx: CSR_UNUSED, default: '0};
      st.is_csr = 1'b1;
      st.idx = idx;
      st.wdata = data;
      return st;
   endfunction

   function automatic blit_step_type pix_row(input logic [CoordW-1:0] col,
                                             input logic [CoordW-1:0] row,
                                             input logic [PixelW-1:0] pix, input logic eor);
      blit_step_type st;
      st = '{idx: CSR_UNUSED, default: '0};
      st.col = col;
      st.row = row;
      st.pix = pix;
      st.eor = eor;
      return st;
   endfunction

   // scale-1 pixel with its single write typed in
   function automatic blit_step_type fixed_row(input logic [CoordW-1:0] col,
                                               input logic [CoordW-1:0] row,
                                               input logic [PixelW-1:0] pix, input logic eor,
                                               input logic [AddrW-1:0] addr,
                                               input logic [PixelW-1:0] wpix, input logic en);
      blit_step_type st;
      st = pix_row(col, row, pix, eor);
      st.typed = 1'b1;
      st.want.addr = addr;
      st.want.pixel = wpix;
      st.want.en = en;
      st.want.last = 1'b1;
      st.want.done = eor;
      return st;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CsrDatW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEST_ORIGIN_X: dest_x_r = data[CoordW-1:0];
         CSR_DEST_ORIGIN_Y: dest_y_r = data[CoordW-1:0];
         CSR_SCALE_FACTOR:  scale_r = data[ScaleW-1:0];
         CSR_RECT_LEFT:     rect_l_r = data[CoordW-1:0];
         CSR_RECT_TOP:      rect_t_r = data[CoordW-1:0];
         CSR_SOURCE_WIDTH:  src_w_r = data;
         CSR_SOURCE_HEIGHT: src_h_r = data;
         default: ;
      endcase
      reg_writes++;
   endtask

   // drop valids and wait until every expected write has come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row,
                             input logic [PixelW-1:0] pix, input logic eor,
                             input bit typed, input fb_write_type want);
      csr_valid <= 1'b0;
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_src_col <= col;
      req_src_row <= row;
      req_src_pixel <= pix;
      req_end_of_rect <= eor;
      do @(posedge clock); while (req_stall);
      if (typed)
         pending_writes.push_back(want);
      else
         replicate_pixel(col, row, pix, eor);
      pixels_sent++;
   endtask

   always @(posedge clock) begin : write_check
      fb_write_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_writes.size() == 0) begin
               report_mismatch("write with nothing pending", rsp_write_address, '0);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_write_address !== want.addr)
                  report_mismatch("write_address", rsp_write_address, want.addr);
               if (rsp_write_pixel !== want.pixel)
                  report_mismatch("write_pixel", rsp_write_pixel, want.pixel);
               if (rsp_write_enable !== want.en)
                  report_mismatch("write_enable", rsp_write_enable, want.en);
               if (rsp_last_replica !== want.last)
                  report_mismatch("last_replica", rsp_last_replica, want.last);
               if (rsp_blit_done !== want.done)
                  report_mismatch("blit_done", rsp_blit_done, want.done);
            end
            writes_seen++;
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 8);
      end
   end

   initial begin : stimulus
      blit_step_type st;
      bit            prev_csr;
      int            sc;
      int            eff;
      int            rw;
      int            rh;
      int            rl;
      int            rt;
      int            dx;
      int            dy;
      int            sw;
      int            sh;
      int            cut;
      int            k;
      int            phase_items;

      // after reset: scale 1, empty source, so every pixel reads as zero
      directed_steps.push_back(fixed_row(0, 0, 32'hFFFF_FFFF, 0, '0, '0, 1));
      directed_steps.push_back(fixed_row(1023, 1023, 32'hA5A5_A5A5, 1, 20'hFFFFF, '0, 1));
      directed_steps.push_back(reg_row(CSR_SOURCE_WIDTH, 11'h400));
      directed_steps.push_back(reg_row(CSR_SOURCE_HEIGHT, 11'h400));
      directed_steps.push_back(fixed_row(1023, 1023, 32'hFFFF_FFFF, 1, 20'hFFFFF,
                                         32'hFFFF_FFFF, 1));
      directed_steps.push_back(fixed_row(0, 0, 32'h0, 0, '0, '0, 1));
      directed_steps.push_back(fixed_row(5, 3, 32'h1234_5678, 0, 20'hC05, 32'h1234_5678, 1));
      directed_steps.push_back(reg_row(CSR_SOURCE_WIDTH, 11'h7FF));
      directed_steps.push_back(reg_row(CSR_SOURCE_HEIGHT, 11'h7FF));
      directed_steps.push_back(pix_row(1023, 0, 32'h8000_0001, 0));
      // destination at the far edge: one column in, the next clipped
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_X, 11'h7FF));
      directed_steps.push_back(fixed_row(0, 0, 32'hDEAD_BEEF, 0, 20'h3FF, 32'hDEAD_BEEF, 1));
      directed_steps.push_back(fixed_row(1, 0, 32'hDEAD_BEEF, 0, '0, 32'hDEAD_BEEF, 0));
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_Y, 11'h7FF));
      directed_steps.push_back(fixed_row(0, 1, 32'hC0FF_EE00, 1, '0, 32'hC0FF_EE00, 0));
      // pixels left of and above the rectangle land off screen
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_X, 11'h000));
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_Y, 11'h000));
      directed_steps.push_back(reg_row(CSR_RECT_LEFT, 11'd10));
      directed_steps.push_back(reg_row(CSR_RECT_TOP, 11'd4));
      directed_steps.push_back(fixed_row(9, 4, 32'h1111_1111, 0, '0, 32'h1111_1111, 0));
      directed_steps.push_back(fixed_row(10, 3, 32'h2222_2222, 0, '0, 32'h2222_2222, 0));
      directed_steps.push_back(fixed_row(10, 4, 32'h3333_3333, 0, '0, 32'h3333_3333, 1));
      // scale zero behaves as one
      directed_steps.push_back(reg_row(CSR_SCALE_FACTOR, 11'h000));
      directed_steps.push_back(fixed_row(12, 6, 32'h4444_4444, 0, 20'h802, 32'h4444_4444, 1));
      directed_steps.push_back(reg_row(CSR_UNUSED, 11'h7FF));
      directed_steps.push_back(pix_row(12, 6, 32'h4444_4444, 1));
      // upper data bits of the scale write are dropped
      directed_steps.push_back(reg_row(CSR_SCALE_FACTOR, 11'h7F2));
      directed_steps.push_back(pix_row(11, 5, 32'h5555_5555, 1));
      directed_steps.push_back(reg_row(CSR_SOURCE_WIDTH, 11'd11));
      directed_steps.push_back(pix_row(11, 5, 32'h5555_5555, 0));
      // oversized scale saturates
      directed_steps.push_back(reg_row(CSR_SCALE_FACTOR, 11'h00F));
      directed_steps.push_back(pix_row(10, 4, 32'h6666_6666, 1));
      directed_steps.push_back(pix_row(1023, 1023, 32'hFFFF_FFFF, 0));
      // replicas straddle the right edge
      directed_steps.push_back(reg_row(CSR_SOURCE_WIDTH, 11'h400));
      directed_steps.push_back(reg_row(CSR_RECT_LEFT, 11'h000));
      directed_steps.push_back(reg_row(CSR_RECT_TOP, 11'h000));
      directed_steps.push_back(reg_row(CSR_SCALE_FACTOR, 11'd3));
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_X, 11'd341));
      directed_steps.push_back(pix_row(0, 0, 32'h7777_7777, 1));
      directed_steps.push_back(reg_row(CSR_SCALE_FACTOR, 11'd8));
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_X, 11'd1023));
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_Y, 11'd1023));
      directed_steps.push_back(pix_row(0, 0, 32'h8888_8888, 0));
      directed_steps.push_back(reg_row(CSR_SOURCE_HEIGHT, 11'h000));
      directed_steps.push_back(pix_row(5, 5, 32'h9999_9999, 1));
      directed_steps.push_back(reg_row(CSR_SCALE_FACTOR, 11'd1));
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_X, 11'h000));
      directed_steps.push_back(reg_row(CSR_DEST_ORIGIN_Y, 11'h000));
      directed_steps.push_back(reg_row(CSR_SOURCE_WIDTH, 11'h000));
      directed_steps.push_back(reg_row(CSR_SOURCE_HEIGHT, 11'h400));
      directed_steps.push_back(fixed_row(0, 0, 32'h1234_5678, 1, '0, '0, 1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_csr = 1'b0;
      foreach (directed_steps[i]) begin
         st = directed_steps[i];
         if (st.is_csr) begin
            if (!prev_csr) wait_idle();
            write_reg(st.idx, st.wdata);
         end else begin
            send_pixel(st.col, st.row, st.pix, st.eor, st.typed, st.want);
         end
         prev_csr = st.is_csr;
      end

      for (int phase = 0; phase < 8; phase++) begin
         calm = (phase == 3);
         wait_idle();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: sc = $urandom_range(1, 2);
            5, 6:          sc = $urandom_range(3, 4);
            7:             sc = 8;
            8:             sc = $urandom_range(5, 7);
            default:       sc = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
         endcase
         eff = (sc == 0) ? 1 : (sc > MaxScale) ? MaxScale : sc;
         rw = $urandom_range(1, 6);
         rh = $urandom_range(1, 4);
         rl = $urandom_range(0, 1023);
         rt = $urandom_range(0, 1023);
         // mostly keep the rectangle on screen, sometimes throw it anywhere
         dx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, FbWidth / eff - rw);
         dy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, FbHeight / eff - rh);
         case ($urandom_range(0, 3))
            0, 1:    sw = rl + rw;
            2:       sw = rl + $urandom_range(0, rw);
            default: sw = $urandom_range(0, 2047);
         endcase
         case ($urandom_range(0, 3))
            0, 1:    sh = rt + rh;
            2:       sh = rt + $urandom_range(0, rh);
            default: sh = $urandom_range(0, 2047);
         endcase
         write_reg(CSR_DEST_ORIGIN_X, {1'($urandom_range(0, 1)), 10'(dx)});
         write_reg(CSR_DEST_ORIGIN_Y, {1'($urandom_range(0, 1)), 10'(dy)});
         write_reg(CSR_SCALE_FACTOR, {7'($urandom), 4'(sc)});
         write_reg(CSR_RECT_LEFT, {1'($urandom_range(0, 1)), 10'(rl)});
         write_reg(CSR_RECT_TOP, {1'($urandom_range(0, 1)), 10'(rt)});
         write_reg(CSR_SOURCE_WIDTH, 11'(sw));
         write_reg(CSR_SOURCE_HEIGHT, 11'(sh));
         if ($urandom_range(0, 2) == 0) write_reg(CSR_UNUSED, 11'($urandom));

         phase_items = 0;
         while (phase_items < 32) begin
            if ($urandom_range(0, 99) < 80) begin
               // raster of the rectangle, now and then cut short before its end mark
               cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, rw * rh) : rw * rh;
               k = 0;
               for (int r = 0; r < rh && k < cut; r++) begin
                  for (int c = 0; c < rw && k < cut; c++) begin
                     k++;
                     send_pixel(10'(rl + c), 10'(rt + r), $urandom, k == rw * rh, 0, '0);
                  end
               end
               phase_items += k;
            end else begin
               send_pixel(10'($urandom), 10'($urandom), $urandom, 1'($urandom), 0, '0);
               phase_items++;
            end
            if ($urandom_range(0, 19) == 0) wait_idle();
         end
      end
      calm = 1'b0;

      wait_idle();
      repeat (8) @(posedge clock);
      if (pending_writes.size() != 0)
         report_mismatch("writes never produced", pending_writes.size(), 0);
      $display("%0d source pixels in, %0d framebuffer writes checked, %0d register writes",
               pixels_sent, writes_seen, reg_writes);
      $display("scales 0 to 15, on-screen, clipped and out-of-source pixels, full and cut rasters");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
